FILE: rtl/core/plut_pkg.sv
// ----------------------------------------------------------------------------
// Price level table package
// Shared item types, result codes and queue command format.
// ----------------------------------------------------------------------------
package plut_pkg;

  localparam int PRICE_W  = 32;
  localparam int AMOUNT_W = 32;
  localparam int STORE_W  = 31;
  localparam int OCC_W    = 7;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_DELETE = 2'd1,
    OP_WRITE  = 2'd2
  } op_t;

  typedef struct packed {
    logic        [PRICE_W-1:0]  price;
    logic signed [AMOUNT_W-1:0] amount;
  } plut_in_t;

  typedef struct packed {
    status_t            status;
    logic [OCC_W-1:0]   occupancy;
  } plut_out_t;

  typedef struct packed {
    op_t                op;
    logic [PRICE_W-1:0] price;
    logic [STORE_W-1:0] amount;
  } plut_cmd_t;

endpackage

FILE: rtl/core/plut_front.sv
// ----------------------------------------------------------------------------
// Price level table front end
// Accepts updates, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module plut_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  plut_pkg::plut_in_t  update,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output plut_pkg::plut_cmd_t cmd
);
  import plut_pkg::*;

  plut_cmd_t  cls;
  plut_cmd_t  q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;
  logic       pop;

  always_comb begin
    cls.price  = update.price;
    cls.amount = update.amount[STORE_W-1:0];
    priority if (update.price == '0) begin
      cls.op = OP_IGNORE;
    end else if (update.amount == '0) begin
      cls.op = OP_DELETE;
    end else if (update.amount[AMOUNT_W-1]) begin
      cls.op = OP_IGNORE;
    end else begin
      cls.op = OP_WRITE;
    end
  end

  assign busy      = (q_cnt == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (q_cnt != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

endmodule

FILE: rtl/core/plut_back.sv
// ----------------------------------------------------------------------------
// Price level table back end
// Parallel key match over the table, then commit of one command.
// ----------------------------------------------------------------------------
module plut_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  plut_pkg::plut_cmd_t cmd,
  output logic                done,
  output plut_pkg::plut_out_t result
);
  import plut_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t                   state;
  state_t                   state_next;
  plut_cmd_t                cur;
  logic                     pop;
  logic [PRICE_W-1:0]       price_q    [TABLE_DEPTH];
  logic [STORE_W-1:0]       amount_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid;
  logic [TABLE_DEPTH-1:0]   hit_comb;
  logic [TABLE_DEPTH-1:0]   hit_vec;
  logic [TABLE_DEPTH-1:0]   free_oh;
  logic [TABLE_DEPTH-1:0]   wr_oh;
  logic                     full;
  logic                     hit_any;
  logic [IW-1:0]            wr_idx;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW+OCC_W-1:0]      occ_ext;
  logic                     commit;
  logic                     do_delete;
  logic                     do_update;
  logic                     do_insert;
  status_t                  status;

  assign cmd_ready = (state == S_IDLE) || (state == S_COMMIT);
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    unique case (state)
      S_IDLE:   state_next = pop ? S_MATCH : S_IDLE;
      S_MATCH:  state_next = S_COMMIT;
      S_COMMIT: state_next = pop ? S_MATCH : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_comb[i] = valid[i] && (price_q[i] == cur.price);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MATCH) begin
      hit_vec <= hit_comb;
      free_oh <= ~valid & (valid + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
      full    <= &valid;
    end
  end

  assign hit_any   = |hit_vec;
  assign commit    = (state == S_COMMIT);
  assign do_delete = commit && (cur.op == OP_DELETE) && hit_any;
  assign do_update = commit && (cur.op == OP_WRITE) && hit_any;
  assign do_insert = commit && (cur.op == OP_WRITE) && !hit_any && !full;
  assign wr_oh     = hit_any ? hit_vec : free_oh;

  always_comb begin
    wr_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (wr_oh[i]) begin
        wr_idx = wr_idx | IW'(i);
      end
    end
  end

  always_comb begin
    count_next = count;
    priority if (do_delete) begin
      status     = ST_DELETED;
      count_next = count - {{(CW-1){1'b0}}, 1'b1};
    end else if (do_update) begin
      status     = ST_UPDATED;
    end else if (do_insert) begin
      status     = ST_INSERTED;
      count_next = count + {{(CW-1){1'b0}}, 1'b1};
    end else if ((cur.op == OP_WRITE) && full) begin
      status     = ST_FULL;
    end else begin
      status     = ST_IGNORED;
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (do_update || do_insert) begin
      amount_mem[wr_idx] <= cur.amount;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (do_insert && free_oh[i]) begin
        price_q[i] <= cur.price;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      if (do_delete) begin
        valid <= valid & ~hit_vec;
      end else if (do_insert) begin
        valid <= valid | free_oh;
      end
      count <= count_next;
      done  <= commit;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.status    <= status;
      result.occupancy <= occ_ext[OCC_W-1:0];
    end
  end

endmodule

FILE: rtl/core/price_level_table_update_unit.sv
// ----------------------------------------------------------------------------
// Price level table update unit
// Keyed table of price levels with insert, overwrite and delete updates.
// ----------------------------------------------------------------------------
// An update passes the queue, the command register, then match and commit;
// done is registered from commit. The back end takes no new command before
// the last reaches commit; a two-entry queue lets start be taken meanwhile.
// The receiver cannot stall: each result is shown for one cycle on done.
// Reset clears the valid bits, the occupancy count and the queue at once.
// ----------------------------------------------------------------------------
module price_level_table_update_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  plut_pkg::plut_in_t  update,
  output logic                done,
  output plut_pkg::plut_out_t result
);
  import plut_pkg::*;

  logic      cmd_valid;
  logic      cmd_ready;
  plut_cmd_t cmd;

  plut_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .update    (update),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  plut_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .done      (done),
    .result    (result)
  );

endmodule

FILE: rtl/core/plut_chk.sv
// ----------------------------------------------------------------------------
// Price level table port checker
// Checks accepted updates, result pacing, ranges and occupancy bookkeeping.
// ----------------------------------------------------------------------------
module plut_chk #(
  parameter int TABLE_DEPTH = 64
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input plut_pkg::plut_in_t  update,
  input logic                done,
  input plut_pkg::plut_out_t result
);
  import plut_pkg::*;

  localparam int OCC_MAX = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(TABLE_DEPTH);

  logic [OCC_W-1:0] prev_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_occ <= '0;
    end else if (done) begin
      prev_occ <= result.occupancy;
    end
  end

  a_known: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown(update))
    else $error("update unknown when accepted");

  a_pacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results closer than two cycles apart");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_FULL) && (32'(result.occupancy) <= OCC_MAX))
    else $error("status or occupancy out of range");

  a_step: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status == ST_INSERTED) &&
              (result.occupancy == prev_occ + 7'd1)) ||
             ((result.status == ST_DELETED) &&
              (result.occupancy == prev_occ - 7'd1)) ||
             ((result.status != ST_INSERTED) && (result.status != ST_DELETED) &&
              (result.occupancy == prev_occ)))
    else $error("occupancy does not follow status");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |-> (result.occupancy == OCC_FULL))
    else $error("full status with free slots");

endmodule

bind price_level_table_update_unit plut_chk #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_plut_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .update (update),
  .done   (done),
  .result (result)
);
